FILE: hw/rtl/twis_pkg.sv
// Shared types and constants for the trie word insert and search block.
`default_nettype none

package twis_pkg;

    localparam int LETTER_W = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_POOL_FULL = 1'b1;

    typedef struct packed {
        logic                action;
        logic [LETTER_W-1:0] letter;
        logic                letter_valid;
        logic                last;
    } t_in;

    typedef struct packed {
        logic found;
        logic status;
    } t_out;

    // Access requests from the word sequencer to the node memory.
    typedef struct packed {
        logic link_rd;
        logic link_wr;
        logic mark_rd;
        logic mark_wr;
    } t_mem_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/trie_word_insert_search.sv
// Trie word insert and search: one letter per input transfer, one result per word.
// A letter without the last mark is handled as a row read at acceptance, then an update.
// A closing insert gives its result from that update; a closing search then also reads
// the end mark of the node reached. Either waits while the output register is still full.
// After reset, a clearing pass zeroes the node pool; input ready is low
// meanwhile. Reset returns the cursor to the root and the free pointer to node one.
`default_nettype none

module trie_word_insert_search #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire twis_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output twis_pkg::t_out       o_out_data
);
    import twis_pkg::*;

    localparam int ADDR_W = $clog2(NODES);
    localparam int LANE_W = $clog2(ALPHABET);
    localparam int CNT_W  = $clog2(NODES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MARK = 2'd2;

    logic [1:0]        r_state, n_state;
    t_in               r_item;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0]  r_next_free, n_next_free;
    logic              r_path_missing, n_path_missing;
    logic              r_pool_full, n_pool_full;
    logic              r_out_valid, n_out_valid;
    t_out              r_out_data, n_out_data;

    t_mem_ctrl                       mem_ctrl;
    logic [ADDR_W-1:0]               mark_addr;
    logic [ALPHABET-1:0][ADDR_W-1:0] rd_links;
    logic                            rd_mark;
    logic                            mem_busy;

    logic              in_fire;
    logic              out_free;
    logic [8:0]        letter_x;
    logic [LANE_W-1:0] lane;
    logic              has_letter;
    logic              is_search;
    logic              descend;
    logic [ADDR_W-1:0] link;
    logic              can_alloc;
    logic              alloc;
    logic [ADDR_W-1:0] cur_new;
    logic              pm_new;
    logic              pf_new;
    logic              halted_new;

    assign o_in_ready = (r_state == S_IDLE) && !mem_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Descent decision for the letter held in r_item, on the row read at acceptance.
    assign letter_x   = 9'(r_item.letter);
    assign lane       = letter_x[LANE_W-1:0];
    assign has_letter = r_item.letter_valid && (letter_x < 9'(ALPHABET));
    assign is_search  = (r_item.action == ACT_SEARCH);
    assign descend    = has_letter && !r_path_missing && !r_pool_full;
    assign link       = rd_links[lane];
    assign can_alloc  = r_next_free < CNT_W'(NODES);
    assign alloc      = descend && (link == '0) && !is_search && can_alloc;

    always_comb begin
        cur_new = r_cursor;
        pm_new  = r_path_missing;
        pf_new  = r_pool_full;
        if (descend) begin
            if (link != '0) begin
                cur_new = link;
            end else if (is_search) begin
                pm_new = 1'b1;
            end else if (can_alloc) begin
                cur_new = r_next_free[ADDR_W-1:0];
            end else begin
                pf_new = 1'b1;
            end
        end
    end

    assign halted_new = pm_new || pf_new;

    always_comb begin
        n_state        = r_state;
        n_cursor       = r_cursor;
        n_next_free    = r_next_free;
        n_path_missing = r_path_missing;
        n_pool_full    = r_pool_full;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_data     = r_out_data;
        mem_ctrl       = '0;
        mem_ctrl.link_rd = in_fire;
        mark_addr      = cur_new;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!(r_item.last && !is_search && !out_free)) begin
                    mem_ctrl.link_wr = alloc;
                    n_next_free      = alloc ? r_next_free + 1'b1 : r_next_free;
                    n_cursor         = cur_new;
                    n_path_missing   = pm_new;
                    n_pool_full      = pf_new;
                    n_state          = S_IDLE;
                    if (r_item.last) begin
                        if (is_search) begin
                            mem_ctrl.mark_rd = 1'b1;
                            n_state          = S_MARK;
                        end else begin
                            mem_ctrl.mark_wr  = !halted_new;
                            n_out_valid       = 1'b1;
                            n_out_data.found  = 1'b0;
                            n_out_data.status = pf_new ? ST_POOL_FULL : ST_OK;
                            n_cursor          = '0;
                            n_path_missing    = 1'b0;
                            n_pool_full       = 1'b0;
                        end
                    end
                end
            end
            S_MARK: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out_data.found  = !(r_path_missing || r_pool_full) && rd_mark;
                    n_out_data.status = ST_OK;
                    n_cursor          = '0;
                    n_path_missing    = 1'b0;
                    n_pool_full       = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cursor       <= '0;
            r_next_free    <= CNT_W'(1);
            r_path_missing <= 1'b0;
            r_pool_full    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cursor       <= n_cursor;
            r_next_free    <= n_next_free;
            r_path_missing <= n_path_missing;
            r_pool_full    <= n_pool_full;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
        r_out_data <= n_out_data;
    end

    twis_node_mem #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_node_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (mem_ctrl),
        .i_link_addr (r_cursor),
        .i_mark_addr (mark_addr),
        .i_wr_lane   (lane),
        .i_wr_link   (r_next_free[ADDR_W-1:0]),
        .o_rd_links  (rd_links),
        .o_rd_mark   (rd_mark),
        .o_busy      (mem_busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_no_write_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctrl.link_wr || mem_ctrl.mark_wr) |-> !mem_busy)
        else $error("node memory written during clearing pass");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= CNT_W'(1)) && (r_next_free <= CNT_W'(NODES)))
        else $error("free node pointer out of range");

    a_cursor_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_cursor) < r_next_free)
        else $error("cursor points at an unallocated node");

    a_single_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_path_missing && r_pool_full))
        else $error("word halted for two reasons at once");

    a_word_close_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && !i_out_ready)) |=> (r_cursor == '0))
        else $error("cursor not back at root after a result");

endmodule

`default_nettype wire

FILE: hw/rtl/twis_node_mem.sv
// Node pool storage: child link rows and end-of-word marks, with a clearing pass after reset.
`default_nettype none

module twis_node_mem #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire twis_pkg::t_mem_ctrl                         i_ctrl,
    input  wire logic [$clog2(NODES)-1:0]                    i_link_addr,
    input  wire logic [$clog2(NODES)-1:0]                    i_mark_addr,
    input  wire logic [$clog2(ALPHABET)-1:0]                 i_wr_lane,
    input  wire logic [$clog2(NODES)-1:0]                    i_wr_link,
    output logic      [ALPHABET-1:0][$clog2(NODES)-1:0]      o_rd_links,
    output logic                                             o_rd_mark,
    output logic                                             o_busy
);
    import twis_pkg::*;

    localparam int ADDR_W = $clog2(NODES);

    logic [ALPHABET-1:0][ADDR_W-1:0] r_link_mem [NODES];
    logic                            r_mark_mem [NODES];

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ADDR_W'(NODES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_link_mem[r_clr_row] <= '0;
        end else if (i_ctrl.link_wr) begin
            r_link_mem[i_link_addr][i_wr_lane] <= i_wr_link;
        end
        if (i_ctrl.link_rd) begin
            o_rd_links <= r_link_mem[i_link_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mark_mem[r_clr_row] <= 1'b0;
        end else if (i_ctrl.mark_wr) begin
            r_mark_mem[i_mark_addr] <= 1'b1;
        end
        if (i_ctrl.mark_rd) begin
            o_rd_mark <= r_mark_mem[i_mark_addr];
        end
    end

    assign o_busy = r_clearing;

endmodule

`default_nettype wire

FILE: tb/trie_word_insert_search_test.sv
// Self-checking testbench for the trie word insert and search block.
`timescale 1ns / 1ps

module trie_word_insert_search_test;

    import twis_pkg::*;

    localparam int NODES       = 1024;
    localparam int ALPHABET    = 26;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 600;
    localparam int VOCAB_MAX   = 200;
    localparam int FILL_LEN    = 16;

    // A dictionary word kept for later reuse: up to eight letters.
    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][4:0] ch;
    } t_word;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   o_in_ready;
    t_in    in_data = '0;
    logic   o_out_valid;
    logic   out_ready = 1'b0;
    t_out   o_out_data;

    trie_word_insert_search #(
        .NODES   (NODES),
        .ALPHABET(ALPHABET)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus and expected word results.
    t_in   letter_queue[$];
    t_out  word_result_q[$];
    t_word vocab[$];

    // Trie mirror.
    int    trie_links[NODES*ALPHABET];
    bit    end_mark[NODES];
    int    node_cursor = 0;
    int    free_node = 1;
    bit    word_missed = 1'b0;
    bit    word_pool_full = 1'b0;

    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_req = 0;
    int    hold_ack = 0;
    int    hold_left = 0;
    bit    in_taken = 1'b0;

    int    fail_count = 0;
    int    cycle_count = 0;
    int    items_queued = 0;
    int    words_checked = 0;
    int    words_found = 0;
    int    words_pool_full = 0;

    task automatic trie_walk(input t_in it);
        int   slot;
        int   child;
        bit   has_letter;
        bit   halted;
        t_out res;
        has_letter = it.letter_valid && (it.letter < ALPHABET);
        if (has_letter && !word_missed && !word_pool_full) begin
            slot  = node_cursor * ALPHABET + int'(it.letter);
            child = trie_links[slot];
            if (child != 0) begin
                node_cursor = child;
            end else if (it.action == ACT_SEARCH) begin
                word_missed = 1'b1;
            end else if (free_node < NODES) begin
                trie_links[slot] = free_node;
                node_cursor = free_node;
                free_node++;
            end else begin
                word_pool_full = 1'b1;
            end
        end
        if (it.last) begin
            halted = word_missed || word_pool_full;
            res.found  = 1'b0;
            res.status = ST_OK;
            if (it.action == ACT_SEARCH) begin
                res.found = !halted && end_mark[node_cursor];
            end else begin
                if (!halted) end_mark[node_cursor] = 1'b1;
                if (word_pool_full) res.status = ST_POOL_FULL;
            end
            word_result_q.push_back(res);
            node_cursor    = 0;
            word_missed    = 1'b0;
            word_pool_full = 1'b0;
        end
    endtask

    task automatic add_item(input logic act, input logic [4:0] ltr, input logic lv,
                            input logic lst);
        t_in it;
        it.action       = act;
        it.letter       = ltr;
        it.letter_valid = lv;
        it.last         = lst;
        letter_queue.push_back(it);
        items_queued++;
    endtask

    task automatic add_word(input logic act, input t_word w);
        for (int i = 0; i < w.len; i++) begin
            // Now and then slip in a letter-less or out-of-alphabet item.
            if ($urandom_range(11) == 0) begin
                if ($urandom_range(1)) add_item(act, 5'($urandom_range(31, 26)), 1'b1, 1'b0);
                else add_item(act, 5'($urandom_range(31)), 1'b0, 1'b0);
            end
            add_item(act, w.ch[i], 1'b1, i == w.len - 1);
        end
    endtask

    // A long random insert word; almost every letter takes a fresh node.
    task automatic add_fill_word();
        for (int i = 0; i < FILL_LEN; i++)
            add_item(ACT_INSERT, 5'($urandom_range(ALPHABET - 1)), 1'b1, i == FILL_LEN - 1);
    endtask

    task automatic gen_random(input int count);
        int    stop_at;
        int    span;
        logic  act;
        t_word w;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            act = logic'($urandom_range(1));
            if ($urandom_range(99) < 20) begin
                // Noise: any field value, words broken or mixed in action.
                add_item(act, 5'($urandom_range(31)), logic'($urandom_range(1)),
                         logic'($urandom_range(1)));
            end else if ($urandom_range(29) == 0) begin
                add_item(act, 5'($urandom_range(31)), 1'b0, 1'b1);
            end else if (vocab.size() > 0 && $urandom_range(1)) begin
                w = vocab[$urandom_range(vocab.size() - 1)];
                if ($urandom_range(3) == 0) w.len = 4'($urandom_range(w.len, 1));
                add_word(act, w);
            end else begin
                // A narrow alphabet makes words share prefixes.
                span  = $urandom_range(1) ? 3 : ALPHABET - 1;
                w     = '0;
                w.len = 4'($urandom_range(6, 1));
                for (int i = 0; i < w.len; i++) w.ch[i] = 5'($urandom_range(span));
                if (act == ACT_INSERT && vocab.size() < VOCAB_MAX) vocab.push_back(w);
                add_word(act, w);
            end
        end
    endtask

    task automatic wait_drained();
        while (letter_queue.size() > 0 || in_valid || word_result_q.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Driver: offers the next pending item once the previous transfer is done.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (letter_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= letter_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here on request from the sequence.
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each output transfer and mirrors each input transfer.
    always @(posedge i_clk) begin
        t_out exp_res;
        in_taken <= in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (word_result_q.size() == 0) begin
                    $display("%0t: unexpected result found=%0b status=%0b", $time,
                             o_out_data.found, o_out_data.status);
                    fail_count++;
                end else begin
                    exp_res = word_result_q.pop_front();
                    words_checked++;
                    if (exp_res.found) words_found++;
                    if (exp_res.status == ST_POOL_FULL) words_pool_full++;
                    if (o_out_data.found !== exp_res.found) begin
                        $display("%0t: found mismatch, expected %0b actual %0b", $time,
                                 exp_res.found, o_out_data.found);
                        fail_count++;
                    end
                    if (o_out_data.status !== exp_res.status) begin
                        $display("%0t: status mismatch, expected %0b actual %0b", $time,
                                 exp_res.status, o_out_data.status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && o_in_ready) trie_walk(in_data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     word_result_q.size());
            $display("FAIL trie_word_insert_search");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NODES * ALPHABET; i++) trie_links[i] = 0;
        for (int i = 0; i < NODES; i++) end_mark[i] = 1'b0;

        // Directed words: empty word, alphabet extremes, prefixes, misses,
        // out-of-alphabet letters, letter-less items and mixed actions.
        add_item(ACT_SEARCH, 5'd0, 1'b0, 1'b1);
        add_item(ACT_INSERT, 5'd7, 1'b0, 1'b1);
        add_item(ACT_SEARCH, 5'd19, 1'b0, 1'b1);
        add_item(ACT_INSERT, 5'd0, 1'b1, 1'b0);
        add_item(ACT_INSERT, 5'd25, 1'b1, 1'b1);
        add_item(ACT_SEARCH, 5'd0, 1'b1, 1'b0);
        add_item(ACT_SEARCH, 5'd25, 1'b1, 1'b1);
        add_item(ACT_SEARCH, 5'd0, 1'b1, 1'b1);
        add_item(ACT_SEARCH, 5'd0, 1'b1, 1'b0);
        add_item(ACT_SEARCH, 5'd25, 1'b1, 1'b0);
        add_item(ACT_SEARCH, 5'd3, 1'b1, 1'b1);
        add_item(ACT_INSERT, 5'd1, 1'b1, 1'b0);
        add_item(ACT_INSERT, 5'd31, 1'b1, 1'b0);
        add_item(ACT_INSERT, 5'd2, 1'b1, 1'b1);
        add_item(ACT_SEARCH, 5'd1, 1'b1, 1'b0);
        add_item(ACT_SEARCH, 5'd26, 1'b0, 1'b0);
        add_item(ACT_SEARCH, 5'd2, 1'b1, 1'b1);
        add_item(ACT_INSERT, 5'd4, 1'b1, 1'b0);
        add_item(ACT_INSERT, 5'd30, 1'b1, 1'b1);
        add_item(ACT_SEARCH, 5'd4, 1'b1, 1'b1);
        add_item(ACT_SEARCH, 5'd16, 1'b1, 1'b0);
        add_item(ACT_INSERT, 5'd17, 1'b1, 1'b1);
        add_item(ACT_SEARCH, 5'd16, 1'b1, 1'b0);
        add_item(ACT_SEARCH, 5'd17, 1'b1, 1'b1);
        add_item(ACT_INSERT, 5'd24, 1'b1, 1'b0);
        add_item(ACT_SEARCH, 5'd24, 1'b1, 1'b1);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        wait_drained();

        set_idling(0, 0);
        gen_random(60);
        wait_drained();
        set_idling(49, 0);
        gen_random(60);
        wait_drained();
        set_idling(0, 49);
        gen_random(60);
        wait_drained();
        set_idling(18, 18);
        gen_random(60);
        wait_drained();

        // The receiver holds off while the sender keeps offering transfers.
        set_idling(0, 0);
        hold_req++;
        gen_random(40);
        wait_drained();

        // Long random inserts use up the node pool; then mixed traffic on a full pool.
        set_idling(18, 18);
        while (free_node < NODES) begin
            add_fill_word();
            wait_drained();
        end
        add_fill_word();
        add_fill_word();
        gen_random(30);
        wait_drained();
        set_idling(49, 49);
        gen_random(30);
        wait_drained();

        repeat (20) @(posedge i_clk);
        $display("Sent %0d letter transfers and checked %0d word results.", items_queued,
                 words_checked);
        $display("Searches found %0d words; %0d inserts hit a full pool (%0d nodes used).",
                 words_found, words_pool_full, free_node);
        if (fail_count == 0) begin
            $display("PASS trie_word_insert_search");
        end else begin
            $display("FAIL trie_word_insert_search");
        end
        $finish;
    end

endmodule
